[rtl/dswr_pkg.sv]
package dswr_pkg;

  // Receiver phase, one-hot
  typedef enum logic [2:0] {
    PH_WAIT_BREAK = 3'b001,
    PH_WAIT_START = 3'b010,
    PH_DATA       = 3'b100
  } phase_t;

  // Captured slot order inside the fixture window
  localparam int unsigned SLOT_COUNT = 5;
  localparam logic [2:0] SLOT_GREEN  = 3'd0;
  localparam logic [2:0] SLOT_RED    = 3'd1;
  localparam logic [2:0] SLOT_BLUE   = 3'd2;
  localparam logic [2:0] SLOT_DIMMER = 3'd3;
  localparam logic [2:0] SLOT_STROBE = 3'd4;

  localparam logic [7:0] STROBE_THRESHOLD = 8'd20;

  // Config space
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_START_ADDRESS = 3'd0;
  localparam logic [8:0] START_ADDRESS_RST = 9'd1;

  // Raw slot values of one complete window
  typedef struct packed {
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
    logic [7:0] dimmer;
    logic [7:0] strobe;
  } frame_t;

  // Parser to scaler hand-off
  typedef struct packed {
    logic   vld;
    frame_t frame;
  } frame_beat_t;

endpackage

[rtl/dswr_parser.sv]
module dswr_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [8:0]           start_addr,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           rx_byte,
  input  logic                 framing_error,
  input  logic                 dn_free,
  output dswr_pkg::frame_beat_t frame_beat
);
  import dswr_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [9:0]  slot_cnt_r, slot_cnt_nxt;
  logic [7:0]  slot_r [SLOT_COUNT-1];
  frame_t      frame_r, frame_nxt;
  logic        frame_vld_r, frame_vld_nxt;

  logic [8:0]  first_slot;
  logic [9:0]  last_slot;
  logic [9:0]  slot_ofs;
  logic        in_window;
  logic        fire;
  logic        accept;

  assign in_tready  = !frame_vld_r || dn_free;
  assign accept     = in_tvalid && in_tready;

  // Start address zero behaves as slot 1
  assign first_slot = (start_addr == 9'd0) ? 9'd1 : start_addr;
  assign last_slot  = {1'b0, first_slot} + 10'(SLOT_COUNT - 1);
  assign slot_ofs   = slot_cnt_r - {1'b0, first_slot};
  assign in_window  = (slot_cnt_r >= {1'b0, first_slot}) && (slot_cnt_r <= last_slot);
  assign fire       = (phase_r == PH_DATA) && (slot_cnt_r == last_slot);

  always_comb begin
    phase_nxt    = phase_r;
    slot_cnt_nxt = slot_cnt_r;
    if (accept) begin
      case (phase_r)
        PH_WAIT_START: begin
          if (!framing_error) begin
            phase_nxt    = PH_DATA;
            slot_cnt_nxt = 10'd1;
          end
        end
        PH_DATA: begin
          // framing errors are not checked inside the slot stream
          slot_cnt_nxt = slot_cnt_r + 10'd1;
          if (fire) begin
            phase_nxt = PH_WAIT_BREAK;
          end
        end
        default: begin
          if (framing_error) begin
            phase_nxt = PH_WAIT_START;
          end
        end
      endcase
    end
  end

  // Last slot of the window is always strobe: take it straight from the beat
  always_comb begin
    frame_nxt        = frame_r;
    frame_vld_nxt    = frame_vld_r && !dn_free;
    if (accept && fire) begin
      frame_nxt.green  = slot_r[SLOT_GREEN[1:0]];
      frame_nxt.red    = slot_r[SLOT_RED[1:0]];
      frame_nxt.blue   = slot_r[SLOT_BLUE[1:0]];
      frame_nxt.dimmer = slot_r[SLOT_DIMMER[1:0]];
      frame_nxt.strobe = rx_byte;
      frame_vld_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT_BREAK;
      slot_cnt_r  <= 10'd0;
      frame_vld_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      slot_cnt_r  <= slot_cnt_nxt;
      frame_vld_r <= frame_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    if (accept && (phase_r == PH_DATA) && in_window && (slot_ofs[2:0] != SLOT_STROBE)) begin
      slot_r[slot_ofs[1:0]] <= rx_byte;
    end
  end

  assign frame_beat.vld   = frame_vld_r;
  assign frame_beat.frame = frame_r;

endmodule

[rtl/dswr_scaler.sv]
module dswr_scaler (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dswr_pkg::frame_beat_t frame_beat,
  output logic                  dn_free,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,
  output logic                  out_tuser
);
  import dswr_pkg::*;

  logic        out_vld_r;
  logic [7:0]  red_r, green_r, blue_r, strobe_r;
  logic        strobe_act_r;

  // floor(c*d/255) for c*d <= 255*255: (x + (x>>8) + 1) >> 8
  function automatic logic [7:0] scale_lvl(input logic [7:0] c, input logic [7:0] d);
    logic [15:0] prod;
    logic [16:0] acc;
    prod = 16'(c) * 16'(d);
    acc  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
    return acc[15:8];
  endfunction

  assign dn_free = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (dn_free) begin
      out_vld_r <= frame_beat.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (dn_free) begin
      red_r        <= scale_lvl(frame_beat.frame.red,   frame_beat.frame.dimmer);
      green_r      <= scale_lvl(frame_beat.frame.green, frame_beat.frame.dimmer);
      blue_r       <= scale_lvl(frame_beat.frame.blue,  frame_beat.frame.dimmer);
      strobe_r     <= frame_beat.frame.strobe;
      strobe_act_r <= frame_beat.frame.strobe > STROBE_THRESHOLD;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {strobe_r, blue_r, green_r, red_r};
  assign out_tuser  = strobe_act_r;

endmodule

[rtl/dmx_slot_window_receiver_unit.sv]
// Channel  | Dir | Beat content
// ---------+-----+-----------------------------------------------------------
// in_      | in  | tdata[7:0] rx_byte, tuser framing_error
// out_     | out | tdata red/green/blue/strobe_value bytes, tuser strobe_active
// cfg_     | in  | APB, reg 0 @ 0x0: start_address[8:0]
//
// One beat per cycle on in_ while in_tready is high. A window result passes
// through the parser frame register and then the scaler (8x8 multiply and
// divide-by-255) output register after the beat carrying the strobe slot.
// Synchronous active-low reset returns to waiting for a break, start address 1.
// Both stages hold under out_tready low; in_tready drops only when both are full.
module dmx_slot_window_receiver_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // in: [7:0] rx_byte
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,
  // in: [0] framing_error
  input  logic                               in_tuser,
  // out: [7:0] red_level, [15:8] green_level, [23:16] blue_level, [31:24] strobe_value
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [31:0]                        out_tdata,
  // out: [0] strobe_active
  output logic                               out_tuser,
  // config
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [dswr_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import dswr_pkg::*;

  logic [8:0]  start_addr_r;
  logic        cfg_wr;
  logic        dn_free;
  frame_beat_t frame_beat;

  // Register file: single start-address register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_addr_r <= START_ADDRESS_RST;
    end else if (cfg_wr && (cfg_paddr == ADDR_START_ADDRESS)) begin
      start_addr_r <= cfg_pwdata[8:0];
    end
  end

  assign cfg_prdata = (cfg_paddr == ADDR_START_ADDRESS) ? {23'd0, start_addr_r} : 32'd0;

  // Break / start code / slot counting, window capture
  dswr_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .start_addr    (start_addr_r),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .rx_byte       (in_tdata),
    .framing_error (in_tuser),
    .dn_free       (dn_free),
    .frame_beat    (frame_beat)
  );

  // Dimmer scaling and result register
  dswr_scaler u_scaler (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_beat (frame_beat),
    .dn_free    (dn_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[rtl/dswr_checker.sv]
module dswr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);
  import dswr_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // flag follows the strobe byte
  a_strobe_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_tdata[31:24] > STROBE_THRESHOLD)))
    else $error("strobe_active mismatch");

  // a fresh result traces back to an accepted input beat
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a source beat");

  // input only backs up when the result side is stalled
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("in_tready low without output stall");

endmodule

bind dmx_slot_window_receiver_unit dswr_checker u_dswr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[verif/dswr_checker.sv]
module dswr_scoreboard (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [7:0]                      in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [31:0]                     out_tdata,
  input  logic                            out_tuser,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [dswr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  input  logic                            cfg_pready,
  output int                              pending,
  output int                              fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import dswr_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] strobe;
    logic       active;
  } fixture_levels_t;

  phase_t          rx_phase;
  logic [8:0]      start_addr;
  logic [9:0]      next_slot;
  logic [7:0]      window_q [SLOT_COUNT];
  fixture_levels_t levels_q [$];

  function automatic logic [7:0] dim_level(logic [7:0] colour, logic [7:0] dimmer);
    logic [15:0] prod;
    prod = 16'(colour) * 16'(dimmer);
    return 8'(prod / 16'd255);
  endfunction

  // one received byte through the slot parser
  function automatic void take_byte(logic [7:0] rx_byte, logic ferr);
    logic [9:0]      first_slot;
    logic [9:0]      last_slot;
    fixture_levels_t res;
    first_slot = (start_addr == '0) ? 10'd1 : {1'b0, start_addr};
    last_slot  = first_slot + 10'(SLOT_COUNT - 1);
    case (rx_phase)
      PH_WAIT_START: begin
        if (!ferr) begin
          rx_phase  = PH_DATA;
          next_slot = 10'd1;
        end
      end
      PH_DATA: begin
        // framing errors are not checked here, byte counts as slot data
        if (next_slot >= first_slot && next_slot <= last_slot)
          window_q[next_slot - first_slot] = rx_byte;
        next_slot = next_slot + 10'd1;
        if (next_slot > last_slot) begin
          res.red    = dim_level(window_q[SLOT_RED], window_q[SLOT_DIMMER]);
          res.green  = dim_level(window_q[SLOT_GREEN], window_q[SLOT_DIMMER]);
          res.blue   = dim_level(window_q[SLOT_BLUE], window_q[SLOT_DIMMER]);
          res.strobe = window_q[SLOT_STROBE];
          res.active = window_q[SLOT_STROBE] > STROBE_THRESHOLD;
          levels_q.push_back(res);
          rx_phase = PH_WAIT_BREAK;
        end
      end
      default: begin
        if (ferr)
          rx_phase = PH_WAIT_START;
      end
    endcase
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    fixture_levels_t want;
    if (!rst_n) begin
      rx_phase   = PH_WAIT_BREAK;
      next_slot  = '0;
      start_addr = START_ADDRESS_RST;
      fail_count = 0;
      levels_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == ADDR_START_ADDRESS)
        start_addr = cfg_pwdata[8:0];
      if (in_tvalid && in_tready)
        take_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (levels_q.size() == 0) begin
          $error("result beat with nothing expected: tdata %h tuser %b", out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = levels_q.pop_front();
          check_field("red_level", want.red, out_tdata[7:0]);
          check_field("green_level", want.green, out_tdata[15:8]);
          check_field("blue_level", want.blue, out_tdata[23:16]);
          check_field("strobe_value", want.strobe, out_tdata[31:24]);
          check_field("strobe_active", {7'd0, want.active}, {7'd0, out_tuser});
        end
      end
    end
    pending <= levels_q.size();
  end

endmodule

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dswr_pkg::*;

  localparam int unsigned LONG_HOLD    = 300;  // receiver hold-off, cycles
  localparam int unsigned DRAIN_CYCLES = 4;    // settle time after the scoreboard drains

  logic        clk;
  logic        rst_n;
  // in: [7:0] rx_byte
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  // in: [0] framing_error
  logic        in_tuser;
  // out: [7:0] red_level, [15:8] green_level, [23:16] blue_level, [31:24] strobe_value
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  // out: [0] strobe_active
  logic        out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          pending;
  int          fail_count;

  int unsigned beat_count;     // accepted input beats
  int unsigned no_idle_left;   // sender back-to-back stretch
  logic        hold_go;        // asks the receiver for one long hold-off

  dmx_slot_window_receiver_unit u_dut (.*);

  // watches all three ports, predicts and scores
  dswr_scoreboard u_chk (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      return 0;
    if (pick < 95)
      return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // slot content biased toward the scaling and strobe corners
  function automatic logic [7:0] slot_byte();
    if ($urandom_range(0, 3) != 0)
      return 8'($urandom);
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd20;
      3:       return 8'd21;
      4:       return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: random tready with quiet stretches, plus one long hold-off
  // once hold_go is raised so the two internal stages fill and in_tready drops.
  // ---------------------------------------------------------------------------
  initial begin : sink
    int unsigned gap;
    bit          hold_used;
    hold_used = 1'b0;
    out_tready <= 1'b0;
    forever begin
      if (hold_go && !hold_used) begin
        hold_used = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if ($urandom_range(0, 5) == 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end else begin
        gap = idle_len();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // One beat on in_. Leaves tvalid high after acceptance; the next call or the
  // caller decides whether it drops.
  task automatic send_beat(input logic [7:0] rx_byte, input logic ferr);
    int unsigned gap;
    if (no_idle_left > 0) begin
      no_idle_left--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      no_idle_left = $urandom_range(10, 40);
      gap = 0;
    end else begin
      gap = idle_len();
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rx_byte;
    in_tuser  <= ferr;
    do @(posedge clk); while (!in_tready);
    beat_count++;
  endtask

  // APB write: setup then access, pready is tied high but still honored.
  // Upper pwdata bits are junk, the register only keeps [8:0].
  task automatic write_start_addr(input logic [8:0] addr);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_START_ADDRESS;
    cfg_pwdata  <= {23'($urandom), addr};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Sender pause: first edge lets pending catch up with the last accepted beat.
  task automatic wait_results();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One DMX packet: optional line noise, break(s), start code, slots up to the
  // end of the window. A broken packet stops early with random flags.
  task automatic send_frame(input int unsigned first_slot, input bit broken);
    int unsigned last_slot;
    int unsigned n_slots;
    last_slot = first_slot + SLOT_COUNT - 1;
    n_slots   = broken ? $urandom_range(0, last_slot - 1) : last_slot;
    repeat ($urandom_range(0, 2)) send_beat(8'($urandom), 1'b0);
    // one or two breaks; a second one lands while waiting for the start code
    repeat ($urandom_range(1, 2)) send_beat(8'($urandom), 1'b1);
    send_beat(8'($urandom), 1'b0);
    for (int unsigned s = 1; s <= n_slots; s++)
      send_beat(broken ? 8'($urandom) : slot_byte(), $urandom_range(0, 15) == 0);
  endtask

  // Set the window, stream packets for about n_beats, then drain.
  task automatic run_phase(input logic [8:0] addr, input int unsigned n_beats);
    int unsigned first_slot;
    int unsigned beats_at_start;
    bit          open;
    write_start_addr(addr);
    first_slot     = (addr == '0) ? 1 : addr;
    beats_at_start = beat_count;
    open           = 1'b0;
    do begin
      if ($urandom_range(0, 7) == 0) begin
        send_frame(first_slot, 1'b1);
        open = 1'b1;
      end else begin
        send_frame(first_slot, 1'b0);
      end
    end while (beat_count - beats_at_start < n_beats);
    // After broken packets the parser may sit anywhere; last+1 clean bytes
    // always bring it back to waiting for a break before the next write.
    if (open)
      repeat (first_slot + SLOT_COUNT) send_beat(8'($urandom), 1'b0);
    in_tvalid <= 1'b0;
    wait_results();
  endtask

  initial begin : stimulus
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    hold_go     <= 1'b0;
    beat_count   = 0;
    no_idle_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, window at reset address 1 ---
    // clean byte before any break is dropped
    send_beat(8'h5A, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);   // break again while waiting for start code
    send_beat(8'hCC, 1'b0);   // start code, value ignored
    send_beat(8'd255, 1'b0);  // green
    send_beat(8'd0, 1'b0);    // red
    send_beat(8'd128, 1'b0);  // blue
    send_beat(8'd255, 1'b0);  // dimmer full
    send_beat(8'd21, 1'b0);   // strobe just over threshold
    send_beat(8'hFF, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'd1, 1'b0);
    send_beat(8'd255, 1'b1);  // framing error inside slots is plain data
    send_beat(8'd254, 1'b0);
    send_beat(8'd0, 1'b0);    // dimmer zero
    send_beat(8'd20, 1'b0);   // strobe at threshold, inactive
    send_beat(8'h80, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'd1, 1'b0);
    send_beat(8'd254, 1'b0);
    send_beat(8'd255, 1'b0);
    send_beat(8'd1, 1'b0);    // dimmer one, floors hard
    send_beat(8'd0, 1'b0);    // strobe zero
    in_tvalid <= 1'b0;
    wait_results();

    // --- random phases ---
    run_phase(9'd0, 20);      // zero address acts as slot 1
    run_phase(9'd5, 20);
    run_phase(9'd508, 1);     // top of the legal range, one long packet
    hold_go <= 1'b1;          // receiver stalls while packets keep coming
    run_phase(9'd1, 100);
    run_phase(9'd2, 20);
    run_phase(9'd511, 1);     // window runs past slot 512
    run_phase(9'd3, 20);
    run_phase(9'($urandom_range(1, 40)), 20);
    run_phase(9'd4, 20);

    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #15_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
